FILE: design/maze_wall_map_unit_assert.svh
// ----------------------------------------------------------------------------
// maze_wall_map_unit_assert.svh
// Assertion macros shared by the wall map checker.
// ----------------------------------------------------------------------------
`ifndef MAZE_WALL_MAP_UNIT_ASSERT_SVH
`define MAZE_WALL_MAP_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MWM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/mwm_pkg.sv
// ----------------------------------------------------------------------------
// mwm_pkg
// Types, codes and wall-bit helpers for the maze wall map.
// ----------------------------------------------------------------------------
`default_nettype none

package mwm_pkg;

    typedef enum logic [1:0] {
        OP_UPDATE = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        DIR_N = 2'd0,
        DIR_E = 2'd1,
        DIR_S = 2'd2,
        DIR_W = 2'd3
    } dir_t;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_EVAL,
        ST_CLEAR
    } state_t;

    localparam logic [3:0] WALL_N = 4'b0001;
    localparam logic [3:0] WALL_E = 4'b0010;
    localparam logic [3:0] WALL_S = 4'b0100;
    localparam logic [3:0] WALL_W = 4'b1000;

    // Decoded item, held while the cell data comes back from the RAM.
    typedef struct packed {
        logic [1:0] op;
        logic       a_ok;
        logic       b_ok;
        logic       same;
        dir_t       dir;
        logic [3:0] sense;
    } item_t;

    function automatic logic [3:0] dir_mask(input dir_t d);
        logic [3:0] m;
        unique case (d)
            DIR_N: m = WALL_N;
            DIR_E: m = WALL_E;
            DIR_S: m = WALL_S;
            DIR_W: m = WALL_W;
            default: m = WALL_N;
        endcase
        return m;
    endfunction

    // Left is one step counterclockwise of the heading, right one step clockwise.
    function automatic logic [3:0] side_mask(input dir_t hd, input logic ahead,
                                             input logic left, input logic right);
        logic [1:0] h;
        logic [3:0] m;
        h = hd;
        m = ({4{ahead}} & dir_mask(hd))
          | ({4{left}}  & dir_mask(dir_t'(h - 2'd1)))
          | ({4{right}} & dir_mask(dir_t'(h + 2'd1)));
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: design/mwm_ram.sv
// ----------------------------------------------------------------------------
// mwm_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mwm_ram #(
    parameter  int WIDTH = 4,
    parameter  int DEPTH = 256,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

`default_nettype wire

FILE: design/mwm_decode.sv
// ----------------------------------------------------------------------------
// mwm_decode
// Grid checks, cell addresses, query direction and sensor wall bits.
// ----------------------------------------------------------------------------
`default_nettype none

module mwm_decode #(
    parameter int GRID_WIDTH  = 16,
    parameter int GRID_HEIGHT = 16,
    parameter int AW          = 8
) (
    input  logic [1:0]        operation,
    input  logic signed [5:0] cell_x,
    input  logic signed [5:0] cell_y,
    input  logic signed [5:0] other_x,
    input  logic signed [5:0] other_y,
    input  logic [1:0]        heading,
    input  logic              wall_ahead,
    input  logic              wall_on_left,
    input  logic              wall_on_right,
    output mwm_pkg::item_t    item,
    output logic [AW-1:0]     addr_a,
    output logic [AW-1:0]     addr_b
);

    import mwm_pkg::*;

    function automatic logic on_grid(input logic signed [5:0] x,
                                     input logic signed [5:0] y);
        return !x[5] && ($unsigned(x) < 6'(GRID_WIDTH))
            && !y[5] && ($unsigned(y) < 6'(GRID_HEIGHT));
    endfunction

    // Only called for in-grid cells, so the low five bits carry the coordinate.
    function automatic logic [AW-1:0] cell_addr(input logic signed [5:0] x,
                                                input logic signed [5:0] y);
        return AW'(int'(y[4:0]) * GRID_WIDTH + int'(x[4:0]));
    endfunction

    logic a_ok;
    logic b_ok;
    dir_t dir;

    assign a_ok = on_grid(cell_x, cell_y);
    assign b_ok = on_grid(other_x, other_y);

    // y decides first, then x
    always_comb
    begin
        if (other_y > cell_y)
            dir = DIR_N;
        else if (other_y < cell_y)
            dir = DIR_S;
        else if (other_x > cell_x)
            dir = DIR_E;
        else
            dir = DIR_W;
    end

    assign item.op    = operation;
    assign item.a_ok  = a_ok;
    assign item.b_ok  = b_ok;
    assign item.same  = (cell_x == other_x) && (cell_y == other_y);
    assign item.dir   = dir;
    assign item.sense = side_mask(dir_t'(heading), wall_ahead, wall_on_left, wall_on_right);

    assign addr_a = a_ok ? cell_addr(cell_x, cell_y) : '0;
    assign addr_b = b_ok ? cell_addr(other_x, other_y) : '0;

endmodule

`default_nettype wire

FILE: design/mwm_result.sv
// ----------------------------------------------------------------------------
// mwm_result
// Forms the result item and the merged mask from the two cells read.
// ----------------------------------------------------------------------------
`default_nettype none

module mwm_result (
    input  mwm_pkg::item_t item,
    input  logic [3:0]     mask_a,
    input  logic [3:0]     mask_b,
    output logic           blocked,
    output logic [3:0]     cell_mask,
    output logic           out_of_grid,
    output logic [3:0]     new_mask
);

    import mwm_pkg::*;

    assign new_mask = mask_a | item.sense;

    always_comb
    begin
        blocked     = 1'b0;
        cell_mask   = '0;
        out_of_grid = 1'b0;
        case (item.op)
            OP_UPDATE:
            begin
                out_of_grid = !item.a_ok;
                cell_mask   = item.a_ok ? new_mask : '0;
            end
            OP_QUERY:
            begin
                cell_mask   = item.a_ok ? mask_a : '0;
                out_of_grid = !(item.a_ok && item.b_ok);
                if (!(item.a_ok && item.b_ok))
                    blocked = 1'b1;
                else if (!item.same)
                    blocked = (|(mask_a & dir_mask(item.dir)))
                            | (|(mask_b & dir_mask(dir_t'(item.dir + 2'd2))));
            end
            default:
            begin
                // clear and the unused code give an all-zero result
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/maze_wall_map_unit.sv
// ----------------------------------------------------------------------------
// maze_wall_map_unit
// Known-wall map of a maze grid: sensor updates, passage queries, clear.
// ----------------------------------------------------------------------------
// An update or a query is accepted in the idle state, which issues a registered
// read of both cells on the two read ports of the map RAM; the eval state then
// forms the result, writes back the merged mask of an update and loads the
// output register, after which the next item is accepted. A clear walks the RAM
// one cell per cycle, then gives an all-zero result through the eval state.
// After reset the same walk over all GRID_WIDTH*GRID_HEIGHT cells runs with
// item_stall high. A result waiting under result_stall holds the block in the eval state.
`default_nettype none

module maze_wall_map_unit #(
    parameter int GRID_WIDTH  = 16,
    parameter int GRID_HEIGHT = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic [1:0]        operation,
    input  logic signed [5:0] cell_x,
    input  logic signed [5:0] cell_y,
    input  logic signed [5:0] other_x,
    input  logic signed [5:0] other_y,
    input  logic [1:0]        heading,
    input  logic              wall_ahead,
    input  logic              wall_on_left,
    input  logic              wall_on_right,
    output logic              result_valid,
    input  logic              result_stall,
    output logic              blocked,
    output logic [3:0]        cell_mask,
    output logic              out_of_grid
);

    import mwm_pkg::*;

    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

    state_t          state_reg, state_next;
    logic [AW-1:0]   sweep_reg, sweep_next;
    item_t           item_reg, item_next;
    logic [AW-1:0]   addr_a_reg, addr_a_next;
    logic [AW-1:0]   addr_b_reg, addr_b_next;
    logic            result_valid_reg, result_valid_next;
    logic            blocked_reg, blocked_next;
    logic [3:0]      cell_mask_reg, cell_mask_next;
    logic            out_of_grid_reg, out_of_grid_next;

    item_t           dec_item;
    logic [AW-1:0]   dec_addr_a;
    logic [AW-1:0]   dec_addr_b;
    logic [AW-1:0]   raddr_a;
    logic [AW-1:0]   raddr_b;
    logic [3:0]      mask_a;
    logic [3:0]      mask_b;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [3:0]      ram_wdata;
    logic            res_blocked;
    logic [3:0]      res_mask;
    logic            res_oog;
    logic [3:0]      new_mask;
    logic            accept;
    logic            out_free;

    mwm_decode #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .AW          (AW)
    ) u_decode (
        .operation     (operation),
        .cell_x        (cell_x),
        .cell_y        (cell_y),
        .other_x       (other_x),
        .other_y       (other_y),
        .heading       (heading),
        .wall_ahead    (wall_ahead),
        .wall_on_left  (wall_on_left),
        .wall_on_right (wall_on_right),
        .item          (dec_item),
        .addr_a        (dec_addr_a),
        .addr_b        (dec_addr_b)
    );

    mwm_ram #(
        .WIDTH (4),
        .DEPTH (CELLS)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (mask_a),
        .rdata_b (mask_b)
    );

    mwm_result u_result (
        .item        (item_reg),
        .mask_a      (mask_a),
        .mask_b      (mask_b),
        .blocked     (res_blocked),
        .cell_mask   (res_mask),
        .out_of_grid (res_oog),
        .new_mask    (new_mask)
    );

    assign accept   = item_valid && (state_reg == ST_IDLE);
    assign out_free = !result_valid_reg || !result_stall;

    // read addresses come straight from the ports in the accept cycle
    assign raddr_a = (state_reg == ST_IDLE) ? dec_addr_a : addr_a_reg;
    assign raddr_b = (state_reg == ST_IDLE) ? dec_addr_b : addr_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_INIT;
            sweep_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sweep_reg        <= sweep_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg        <= item_next;
        addr_a_reg      <= addr_a_next;
        addr_b_reg      <= addr_b_next;
        blocked_reg     <= blocked_next;
        cell_mask_reg   <= cell_mask_next;
        out_of_grid_reg <= out_of_grid_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        sweep_next        = sweep_reg;
        item_next         = item_reg;
        addr_a_next       = addr_a_reg;
        addr_b_next       = addr_b_reg;
        result_valid_next = result_valid_reg && result_stall;
        blocked_next      = blocked_reg;
        cell_mask_next    = cell_mask_reg;
        out_of_grid_next  = out_of_grid_reg;
        ram_we            = 1'b0;
        ram_waddr         = addr_a_reg;
        ram_wdata         = new_mask;
        unique case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_reg;
                ram_wdata = '0;
                if (sweep_reg == LAST_CELL)
                begin
                    sweep_next = '0;
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_EVAL;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next   = dec_item;
                    addr_a_next = dec_addr_a;
                    addr_b_next = dec_addr_b;
                    case (operation)
                        OP_CLEAR: state_next = ST_CLEAR;
                        default:  state_next = ST_EVAL;
                    endcase
                end
            end
            ST_EVAL:
            begin
                if (out_free)
                begin
                    ram_we            = (item_reg.op == OP_UPDATE) && item_reg.a_ok;
                    result_valid_next = 1'b1;
                    blocked_next      = res_blocked;
                    cell_mask_next    = res_mask;
                    out_of_grid_next  = res_oog;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign blocked      = blocked_reg;
    assign cell_mask    = cell_mask_reg;
    assign out_of_grid  = out_of_grid_reg;

endmodule

`default_nettype wire

FILE: design/mwm_checker.sv
// ----------------------------------------------------------------------------
// mwm_checker
// Port-level checks of the wall map unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "maze_wall_map_unit_assert.svh"

module mwm_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input logic [1:0]        operation,
    input logic              result_valid,
    input logic              result_stall,
    input logic              blocked,
    input logic [3:0]        cell_mask,
    input logic              out_of_grid
);

    import mwm_pkg::*;

    logic item_acc;

    assign item_acc = item_valid && !item_stall;

    // a held result keeps its fields
    `MWM_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall,
        result_valid && $stable(blocked) && $stable(cell_mask) && $stable(out_of_grid),
        "result changed while stalled")

    // one item in flight: no accept right after an accept
    `MWM_ASSERT_NEXT(a_one_in_flight, clk, rst_n, item_acc, item_stall,
        "item accepted while busy")

    // off-grid update gives an empty mask, off-grid query is blocked
    `MWM_ASSERT_NOW(a_oog_result, clk, rst_n, result_valid && out_of_grid,
        blocked || (cell_mask == 4'd0), "off-grid result inconsistent")

    // a query reaches the output once the output side is free
    `MWM_ASSERT_NEXT(a_query_latency, clk, rst_n,
        (item_acc && (operation == OP_QUERY)) ##1 (!result_valid || !result_stall),
        result_valid, "query result late")

endmodule

bind maze_wall_map_unit mwm_checker u_mwm_checker (.*);

`default_nettype wire
